// File: src/dlrc_pkg.sv
// Shared types and constants of the stereo left-right consistency checker.
package dlrc_pkg;

	localparam int COLUMN_W = 10;
	localparam int DISP_W   = 15;
	localparam int THRESH_W = 14;
	localparam int ROWW_W   = 11;
	localparam int ENTRY_W  = DISP_W + 1;
	localparam int PADDR_W  = 4;
	localparam int PDATA_W  = 32;

	localparam logic [THRESH_W-1:0] THRESH_RESET = 14'd16;
	localparam logic                MODE_RESET   = 1'b1;
	localparam logic [ROWW_W-1:0]   ROWW_RESET   = 11'd1024;

	// Test selection and item kind.
	localparam logic TEST_ABSOLUTE = 1'b1;
	localparam logic MODE_LOAD     = 1'b0;

	// Register indexes, taken from paddr[3:2].
	localparam logic [1:0] REG_THRESHOLD = 2'd0;
	localparam logic [1:0] REG_TEST_MODE = 2'd1;
	localparam logic [1:0] REG_ROW_WIDTH = 2'd2;

	typedef struct packed {
		logic [THRESH_W-1:0] threshold;
		logic                test_mode;
		logic [ROWW_W-1:0]   row_width;
	} cfg_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_INTERP,
		S_TEST,
		S_DONE
	} state_t;

endpackage

// File: src/dlrc_if.sv
// Valid/ready channel interfaces for pixel items and check results.
interface dlrc_in_if import dlrc_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic                      mode;
	logic [COLUMN_W-1:0]       column;
	logic signed [DISP_W-1:0]  disparity;
	logic                      disparity_valid;

	modport source (output valid, mode, column, disparity, disparity_valid, input ready);
	modport sink (input valid, mode, column, disparity, disparity_valid, output ready);
endinterface

interface dlrc_out_if import dlrc_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic [COLUMN_W-1:0]       out_column;
	logic signed [DISP_W-1:0]  out_disparity;
	logic                      out_valid;
	logic                      was_rejected;

	modport source (output valid, out_column, out_disparity, out_valid, was_rejected,
		input ready);
	modport sink (input valid, out_column, out_disparity, out_valid, was_rejected,
		output ready);
endinterface

// File: src/dlrc_cfg_regs.sv
// APB-style register bank holding threshold, test mode and row width.
module dlrc_cfg_regs import dlrc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	output cfg_t               cfg
);

	cfg_t       cfg_q;
	logic [1:0] reg_idx;
	logic       wr_en;

	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	assign wr_en   = psel && penable && pwrite && pready;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.threshold <= THRESH_RESET;
			cfg_q.test_mode <= MODE_RESET;
			cfg_q.row_width <= ROWW_RESET;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_THRESHOLD: cfg_q.threshold <= pwdata[THRESH_W-1:0];
				REG_TEST_MODE: cfg_q.test_mode <= pwdata[0];
				REG_ROW_WIDTH: cfg_q.row_width <= pwdata[ROWW_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_THRESHOLD: prdata = PDATA_W'(cfg_q.threshold);
			REG_TEST_MODE: prdata = PDATA_W'(cfg_q.test_mode);
			REG_ROW_WIDTH: prdata = PDATA_W'(cfg_q.row_width);
			default:       prdata = '0;
		endcase
	end

endmodule

// File: src/dlrc_row_mem.sv
// Right-row memory: one write port, two registered read ports.
module dlrc_row_mem import dlrc_pkg::*; #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10
) (
	input  logic               clk,
	input  logic               we,
	input  logic [AW-1:0]      waddr,
	input  logic [ENTRY_W-1:0] wdata,
	input  logic [AW-1:0]      raddr0,
	input  logic [AW-1:0]      raddr1,
	output logic [ENTRY_W-1:0] rdata0,
	output logic [ENTRY_W-1:0] rdata1
);

	logic [ENTRY_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata0 <= mem[raddr0];
		rdata1 <= mem[raddr1];
	end

endmodule

// File: src/disparity_lr_consistency_check.sv
// Top level of the stereo left-right consistency checker.
//
//   channel  dir  handshake      payload
//   pixel    in   valid/ready    mode, column, disparity, disparity_valid
//   result   out  valid/ready    out_column, out_disparity, out_valid, was_rejected
//   apb      in   psel/penable   paddr, pwdata -> prdata; pready tied high
//
// One item is in flight at a time. A load transaction is a capture, then the memory
// write. A check transaction runs capture, dual-port row read, interpolation
// multiply, threshold multiply, compare; the row memory read and the two multiplier
// stages are registered. The finished result sits in an output register, so the next
// pixel is taken while it waits; a stalled result only holds the compare stage once a
// second check reaches it. After reset the row memory is undefined and needs no
// clearing pass; control state clears at once.
module disparity_lr_consistency_check import dlrc_pkg::*; #(
	parameter int MAX_WIDTH = 1024,
	parameter int FRAC_BITS = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	dlrc_in_if.sink            pixel,
	dlrc_out_if.source         result,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	// Address width of the row memory, width for row-width arithmetic, width of the
	// signed sample position, of the fraction (it can reach one), of the
	// interpolated disparity, and of the final compare.
	localparam int AW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int WCLOG = $clog2(MAX_WIDTH + 1);
	localparam int WW    = (WCLOG > ROWW_W) ? WCLOG : ROWW_W;
	localparam int PW    = WW + FRAC_BITS + 6;
	localparam int ONE_W = FRAC_BITS + 1;
	localparam int DW    = DISP_W + FRAC_BITS + 3;
	localparam int MW    = DW + THRESH_W + FRAC_BITS + 1;

	localparam logic [ONE_W-1:0] ONE       = ONE_W'(1) << FRAC_BITS;
	localparam logic [PW-1:0]    FRAC_MASK = (PW'(1) << FRAC_BITS) - PW'(1);
	localparam logic [WW-1:0]    WMAX      = WW'(MAX_WIDTH);

	cfg_t cfg;

	dlrc_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	state_t state_q, state_d;

	// Captured pixel transaction; held until the item retires.
	logic                     mode_q;
	logic [COLUMN_W-1:0]      col_q;
	logic signed [DISP_W-1:0] disp_q;
	logic                     dvalid_q;

	logic in_acc;
	logic out_free;
	logic mem_we;

	assign in_acc   = pixel.valid && pixel.ready;
	assign out_free = !result.valid || result.ready;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:   if (in_acc) state_d = S_READ;
			S_READ:   state_d = (mode_q == MODE_LOAD) ? S_IDLE : S_INTERP;
			S_INTERP: state_d = S_TEST;
			S_TEST:   state_d = S_DONE;
			S_DONE:   if (out_free) state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Load columns past the memory are dropped.
	logic col_fits;
	assign col_fits = (WW'(col_q) < WMAX);

	// State outputs.
	always_comb begin
		pixel.ready = 1'b0;
		mem_we      = 1'b0;
		unique case (state_q)
			S_IDLE:   pixel.ready = 1'b1;
			S_READ:   mem_we = (mode_q == MODE_LOAD) && col_fits;
			S_INTERP,
			S_TEST,
			S_DONE:   ;
			default:  ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			mode_q   <= pixel.mode;
			col_q    <= pixel.column;
			disp_q   <= pixel.disparity;
			dvalid_q <= pixel.disparity_valid;
		end
	end

	// ---- Sample position and neighbor addresses ----
	logic [WW-1:0]        row_w;
	logic [WW-1:0]        w_eff;
	logic signed [PW-1:0] pos;
	logic signed [PW-1:0] last_pos;
	logic signed [PW-1:0] i0_full;
	logic                 w_ok;
	logic                 in_range;
	logic                 at_last;
	logic [AW-1:0]        addr0;
	logic [AW-1:0]        addr1;
	logic [ONE_W-1:0]     frac;

	always_comb begin
		row_w    = WW'(cfg.row_width);
		w_eff    = (row_w > WMAX) ? WMAX : row_w;
		w_ok     = (w_eff >= WW'(2));
		pos      = (PW'(col_q) << FRAC_BITS) + PW'(disp_q);
		last_pos = PW'(w_eff - WW'(1)) << FRAC_BITS;
		in_range = !pos[PW-1] && (pos <= last_pos);
		at_last  = (pos == last_pos);
		i0_full  = pos >>> FRAC_BITS;
		// A position on the last column takes the last pair with full weight on the
		// right neighbor.
		if (at_last) begin
			addr0 = AW'(w_eff - WW'(2));
			frac  = ONE;
		end else begin
			addr0 = AW'(i0_full);
			frac  = ONE_W'(pos & FRAC_MASK);
		end
		addr1 = addr0 + AW'(1);
	end

	logic [ENTRY_W-1:0] rdata0;
	logic [ENTRY_W-1:0] rdata1;

	dlrc_row_mem #(
		.DEPTH (MAX_WIDTH),
		.AW    (AW)
	) u_mem (
		.clk    (clk),
		.we     (mem_we),
		.waddr  (AW'(col_q)),
		.wdata  ({dvalid_q, disp_q}),
		.raddr0 (addr0),
		.raddr1 (addr1),
		.rdata0 (rdata0),
		.rdata1 (rdata1)
	);

	// Position checks travel with the read.
	logic             go_s1;
	logic [ONE_W-1:0] frac_s1;

	always_ff @(posedge clk) begin
		if (state_q == S_READ) begin
			go_s1   <= dvalid_q && w_ok && in_range;
			frac_s1 <= frac;
		end
	end

	// ---- Linear interpolation in Q.(2*FRAC_BITS) ----
	logic signed [DISP_W-1:0] r0;
	logic signed [DISP_W-1:0] r1;
	logic [ONE_W-1:0]         wgt0;
	logic signed [DW-1:0]     p0;
	logic signed [DW-1:0]     p1;
	logic signed [DW-1:0]     drs_s2;
	logic                     ok_s2;

	always_comb begin
		r0   = rdata0[DISP_W-1:0];
		r1   = rdata1[DISP_W-1:0];
		wgt0 = ONE - frac_s1;
		p0   = DW'(r0) * DW'({1'b0, wgt0});
		p1   = DW'(r1) * DW'({1'b0, frac_s1});
	end

	always_ff @(posedge clk) begin
		if (state_q == S_INTERP) begin
			drs_s2 <= p0 + p1;
			ok_s2  <= go_s1 && rdata0[ENTRY_W-1] && rdata1[ENTRY_W-1];
		end
	end

	// ---- Sum and difference magnitudes, threshold product ----
	logic signed [DW-1:0] dls;
	logic signed [DW-1:0] sum;
	logic signed [DW-1:0] diff;
	logic [DW-1:0]        e_mag;
	logic [DW-1:0]        d_mag;
	logic [DW-1:0]        e_s3;
	logic [MW-1:0]        tdp_s3;

	always_comb begin
		dls   = DW'(disp_q) <<< FRAC_BITS;
		sum   = dls + drs_s2;
		diff  = dls - drs_s2;
		e_mag = sum[DW-1] ? DW'(-sum) : DW'(sum);
		d_mag = diff[DW-1] ? DW'(-diff) : DW'(diff);
	end

	always_ff @(posedge clk) begin
		if (state_q == S_TEST) begin
			e_s3   <= e_mag;
			tdp_s3 <= MW'(cfg.threshold) * MW'(d_mag);
		end
	end

	// ---- Decision and output register ----
	logic [MW-1:0] e_abs;
	logic [MW-1:0] e_rel;
	logic [MW-1:0] thr_abs;
	logic          keep;

	always_comb begin
		e_abs   = MW'(e_s3);
		e_rel   = MW'(e_s3) << (FRAC_BITS + 1);
		thr_abs = MW'(cfg.threshold) << FRAC_BITS;
		if (cfg.test_mode == TEST_ABSOLUTE) begin
			keep = ok_s2 && !(e_abs > thr_abs);
		end else begin
			keep = ok_s2 && !(e_rel > tdp_s3);
		end
	end

	logic                     res_v_q;
	logic [COLUMN_W-1:0]      res_col_q;
	logic signed [DISP_W-1:0] res_disp_q;
	logic                     res_keep_q;
	logic                     res_rej_q;
	logic                     res_load;

	assign res_load = (state_q == S_DONE) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_v_q <= 1'b0;
		end else if (res_load) begin
			res_v_q <= 1'b1;
		end else if (result.ready) begin
			res_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_col_q  <= col_q;
			res_disp_q <= disp_q;
			res_keep_q <= keep;
			res_rej_q  <= dvalid_q && !keep;
		end
	end

	assign result.valid         = res_v_q;
	assign result.out_column    = res_col_q;
	assign result.out_disparity = res_disp_q;
	assign result.out_valid     = res_keep_q;
	assign result.was_rejected  = res_rej_q;

endmodule

// File: src/dlrc_checker.sv
// Port-level assertions for the consistency checker, bound to the top level.
module dlrc_checker import dlrc_pkg::*; (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     in_valid,
	input logic                     in_ready,
	input logic                     res_valid,
	input logic                     res_ready,
	input logic [COLUMN_W-1:0]      res_col,
	input logic signed [DISP_W-1:0] res_disp,
	input logic                     res_keep,
	input logic                     res_rej,
	input logic                     psel,
	input logic                     penable,
	input logic                     pwrite,
	input logic                     pready,
	input logic [PADDR_W-1:0]       paddr,
	input logic [PDATA_W-1:0]       pwdata,
	input logic [PDATA_W-1:0]       prdata
);

	// Hold a stalled result.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result dropped while stalled");

	a_res_stable: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> $stable(res_col) && $stable(res_disp)
			&& $stable(res_keep) && $stable(res_rej))
		else $error("result payload changed while stalled");

	// One item at a time: the block is busy right after taking a pixel.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("pixel accepted while an item is in flight");

	// A threshold write reads back on the next cycle.
	a_thresh_readback: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && pwrite && pready && (paddr[3:2] == REG_THRESHOLD)
		|=> (paddr[3:2] != REG_THRESHOLD)
			|| (prdata[THRESH_W-1:0] == $past(pwdata[THRESH_W-1:0])))
		else $error("threshold readback mismatch");

endmodule

bind disparity_lr_consistency_check dlrc_checker u_dlrc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (pixel.valid),
	.in_ready  (pixel.ready),
	.res_valid (result.valid),
	.res_ready (result.ready),
	.res_col   (result.out_column),
	.res_disp  (result.out_disparity),
	.res_keep  (result.out_valid),
	.res_rej   (result.was_rejected),
	.psel      (psel),
	.penable   (penable),
	.pwrite    (pwrite),
	.pready    (pready),
	.paddr     (paddr),
	.pwdata    (pwdata),
	.prdata    (prdata)
);
